// File: rtl/dts_pkg.sv
// Package for the delimited token splitter: phase and register codes,
// the queue entry type and reset constants. No dependencies.
`default_nettype none
package dts_pkg;

  typedef enum logic [1:0] {
    PH_SKIP    = 2'd0,
    PH_COMMENT = 2'd1,
    PH_TOKEN   = 2'd2,
    PH_QUOTED  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    REG_BREAK_LOW    = 3'd0,
    REG_BREAK_MID    = 3'd1,
    REG_BREAK_HIGH_A = 3'd2,
    REG_BREAK_HIGH_B = 3'd3,
    REG_QUOTE        = 3'd4
  } cfg_reg_e;

  // Results caused by one accepted byte: an optional token byte, then an
  // optional end marker.
  typedef struct packed {
    logic       has_byte;
    logic [7:0] tok_byte;
    logic       has_end;
    logic       trunc;
  } entry_t;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam logic [255:0] BREAK_SET_RESET = {192'h0, 64'h0800_0001_0000_2600};
  localparam logic [7:0]   QUOTE_RESET     = 8'd34;
  localparam logic [7:0]   CHAR_SEMI       = 8'd59;
  localparam logic [7:0]   CHAR_LF         = 8'd10;
  localparam logic [7:0]   CHAR_NUL        = 8'd0;

endpackage
`default_nettype wire

// File: rtl/dts_front.sv
// Front end of the token splitter: configuration registers, byte
// classification and scan state. Emits one queue entry per productive byte.
// Depends on dts_pkg.
`default_nettype none
module dts_front #(
  parameter int unsigned MAX_TOKEN_LEN = 256
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [dts_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [dts_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                               text_valid_i,
  output logic                                    text_ready_o,
  input  wire logic [7:0]                         text_byte_i,
  input  wire logic                               q_full_i,
  output logic                                    q_push_o,
  output dts_pkg::entry_t                         q_entry_o
);

  localparam int unsigned LEN_W = $clog2(MAX_TOKEN_LEN + 1);

  logic [255:0]      break_set_q, break_set_d;
  logic [7:0]        quote_q, quote_d;
  dts_pkg::phase_e   phase_q, phase_d;
  logic [LEN_W-1:0]  len_q, len_d;

  logic              accept;
  logic              is_nul, is_brk, is_quote, is_semi, is_lf;
  logic              in_token, at_max;
  logic [LEN_W-1:0]  base_len, new_len;
  dts_pkg::entry_t   entry;

  assign text_ready_o = !q_full_i;
  assign accept       = text_valid_i && text_ready_o;

  assign is_nul   = (text_byte_i == dts_pkg::CHAR_NUL);
  assign is_brk   = !is_nul && break_set_q[text_byte_i];
  assign is_quote = (text_byte_i == quote_q);
  assign is_semi  = (text_byte_i == dts_pkg::CHAR_SEMI);
  assign is_lf    = (text_byte_i == dts_pkg::CHAR_LF);
  assign in_token = (phase_q == dts_pkg::PH_TOKEN) || (phase_q == dts_pkg::PH_QUOTED);
  assign base_len = in_token ? len_q : '0;
  assign new_len  = base_len + LEN_W'(1);
  assign at_max   = (new_len >= LEN_W'(MAX_TOKEN_LEN));

  always_comb begin
    break_set_d = break_set_q;
    quote_d     = quote_q;
    if (cfg_we_i) begin
      unique case (dts_pkg::cfg_reg_e'(cfg_index_i))
        dts_pkg::REG_BREAK_LOW:    break_set_d[0   +: 64] = cfg_data_i;
        dts_pkg::REG_BREAK_MID:    break_set_d[64  +: 64] = cfg_data_i;
        dts_pkg::REG_BREAK_HIGH_A: break_set_d[128 +: 64] = cfg_data_i;
        dts_pkg::REG_BREAK_HIGH_B: break_set_d[192 +: 64] = cfg_data_i;
        dts_pkg::REG_QUOTE:        quote_d = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    if (accept) begin
      priority if (is_nul) begin
        phase_d = dts_pkg::PH_SKIP;
        len_d   = '0;
      end else begin
        unique case (phase_q)
          dts_pkg::PH_SKIP, dts_pkg::PH_COMMENT: begin
            if (phase_q == dts_pkg::PH_SKIP || is_lf) begin
              priority if (is_brk) begin
                phase_d = is_semi ? dts_pkg::PH_COMMENT : dts_pkg::PH_SKIP;
              end else if (is_quote) begin
                phase_d = dts_pkg::PH_QUOTED;
                len_d   = '0;
              end else if (at_max) begin
                phase_d = dts_pkg::PH_SKIP;
                len_d   = '0;
              end else begin
                phase_d = dts_pkg::PH_TOKEN;
                len_d   = new_len;
              end
            end
          end
          dts_pkg::PH_TOKEN: begin
            priority if (is_brk) begin
              phase_d = is_semi ? dts_pkg::PH_COMMENT : dts_pkg::PH_SKIP;
              len_d   = '0;
            end else if (is_quote) begin
              phase_d = dts_pkg::PH_QUOTED;
            end else if (at_max) begin
              phase_d = dts_pkg::PH_SKIP;
              len_d   = '0;
            end else begin
              len_d = new_len;
            end
          end
          dts_pkg::PH_QUOTED: begin
            priority if (is_quote || at_max) begin
              phase_d = dts_pkg::PH_SKIP;
              len_d   = '0;
            end else begin
              len_d = new_len;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Outputs
  always_comb begin
    entry          = '0;
    entry.tok_byte = text_byte_i;
    priority if (is_nul) begin
      entry.has_end = in_token;
    end else begin
      unique case (phase_q)
        dts_pkg::PH_SKIP, dts_pkg::PH_COMMENT: begin
          if ((phase_q == dts_pkg::PH_SKIP || is_lf) && !is_brk && !is_quote) begin
            entry.has_byte = 1'b1;
            entry.has_end  = at_max;
            entry.trunc    = at_max;
          end
        end
        dts_pkg::PH_TOKEN: begin
          if (is_brk) begin
            entry.has_end = 1'b1;
          end else if (!is_quote) begin
            entry.has_byte = 1'b1;
            entry.has_end  = at_max;
            entry.trunc    = at_max;
          end
        end
        dts_pkg::PH_QUOTED: begin
          priority if (is_quote) begin
            entry.has_end = 1'b1;
          end else begin
            entry.has_byte = 1'b1;
            entry.has_end  = at_max;
            entry.trunc    = at_max;
          end
        end
        default: ;
      endcase
    end
  end

  assign q_entry_o = entry;
  assign q_push_o  = accept && (entry.has_byte || entry.has_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      break_set_q <= dts_pkg::BREAK_SET_RESET;
      quote_q     <= dts_pkg::QUOTE_RESET;
      phase_q     <= dts_pkg::PH_SKIP;
      len_q       <= '0;
    end else begin
      break_set_q <= break_set_d;
      quote_q     <= quote_d;
      phase_q     <= phase_d;
      len_q       <= len_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/dts_queue.sv
// Short queue of result entries between front and back of the token
// splitter. Depends on dts_pkg.
`default_nettype none
module dts_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire dts_pkg::entry_t  push_entry_i,
  input  wire logic             pop_i,
  output dts_pkg::entry_t       head_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned DEPTH = dts_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dts_pkg::entry_t   slots_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slots_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/dts_back.sv
// Back end of the token splitter: expands queue entries into one or two
// results and drives the output register. Depends on dts_pkg.
`default_nettype none
module dts_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dts_pkg::entry_t  head_i,
  input  wire logic             empty_i,
  output logic                  pop_o,
  output logic                  token_valid_o,
  input  wire logic             token_ready_i,
  output logic [7:0]            token_byte_o,
  output logic                  token_end_o,
  output logic                  truncated_o
);

  logic        valid_q, valid_d;
  logic        half_q, half_d;
  logic [7:0]  byte_q, byte_d;
  logic        end_q, end_d;
  logic        trunc_q, trunc_d;
  logic        load;

  assign load = !valid_q || token_ready_i;

  always_comb begin
    valid_d = valid_q;
    half_d  = half_q;
    byte_d  = byte_q;
    end_d   = end_q;
    trunc_d = trunc_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        priority if (head_i.has_byte && !half_q) begin
          byte_d  = head_i.tok_byte;
          end_d   = 1'b0;
          trunc_d = 1'b0;
          half_d  = head_i.has_end;
          pop_o   = !head_i.has_end;
        end else begin
          byte_d  = 8'd0;
          end_d   = 1'b1;
          trunc_d = head_i.trunc;
          half_d  = 1'b0;
          pop_o   = 1'b1;
        end
      end
    end
  end

  assign token_valid_o = valid_q;
  assign token_byte_o  = byte_q;
  assign token_end_o   = end_q;
  assign truncated_o   = trunc_q;

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    end_q   <= end_d;
    trunc_q <= trunc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      half_q  <= half_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/delimited_token_splitter_unit.sv
// Top level of the delimited token splitter: front end, result queue and
// back end. Depends on dts_pkg, dts_front, dts_queue and dts_back.
//
// Takes one text byte per cycle while the queue is not full and returns token
// bytes and end markers, one result per cycle while the consumer is ready,
// through a registered output. A byte yields one result or none, or, if it
// completes a token at MAX_TOKEN_LEN, the byte and a truncated end marker.
// The output port sets the sustained rate; a four-entry queue lets input and
// output stall independently. Configuration writes take effect at the next
// edge. The user must make them while the block is idle; nothing enforces it.
`default_nettype none
module delimited_token_splitter_unit #(
  parameter int unsigned MAX_TOKEN_LEN = 256
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [dts_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [dts_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                             text_valid_i,
  output logic                                  text_ready_o,
  input  wire logic [7:0]                       text_byte_i,
  output logic                                  token_valid_o,
  input  wire logic                             token_ready_i,
  output logic [7:0]                            token_byte_o,
  output logic                                  token_end_o,
  output logic                                  truncated_o
);

  dts_pkg::entry_t push_entry, head_entry;
  logic            push, pop, full, empty;

  dts_front #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .text_valid_i (text_valid_i),
    .text_ready_o (text_ready_o),
    .text_byte_i  (text_byte_i),
    .q_full_i     (full),
    .q_push_o     (push),
    .q_entry_o    (push_entry)
  );

  dts_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head_entry),
    .full_o       (full),
    .empty_o      (empty)
  );

  dts_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_entry),
    .empty_i       (empty),
    .pop_o         (pop),
    .token_valid_o (token_valid_o),
    .token_ready_i (token_ready_i),
    .token_byte_o  (token_byte_o),
    .token_end_o   (token_end_o),
    .truncated_o   (truncated_o)
  );

endmodule
`default_nettype wire
